// File: src/bdeq_pkg.sv
// shared types, constants and index helpers for the bounded double-ended queue
package bdeq_pkg;

  localparam int Depth = 16;
  localparam int DataW = 32;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int CapW  = 5;
  localparam int ActW  = 3;
  localparam int OutCntW = 5;

  localparam logic [ActW-1:0] ActInsFront = 3'd0;
  localparam logic [ActW-1:0] ActInsRear  = 3'd1;
  localparam logic [ActW-1:0] ActDelFront = 3'd2;
  localparam logic [ActW-1:0] ActDelRear  = 3'd3;
  localparam logic [ActW-1:0] ActNop      = 3'd4;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef struct packed {
    logic [ActW-1:0]         action;
    logic signed [DataW-1:0] value;
  } in_t;

  typedef struct packed {
    logic                    ok;
    logic signed [DataW-1:0] front_value;
    logic signed [DataW-1:0] rear_value;
    logic                    is_empty;
    logic                    is_full;
    logic [OutCntW-1:0]      count;
  } out_t;

  // pointer update produced for one transaction
  typedef struct packed {
    logic            ok;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [IdxW-1:0] head_nxt;
    logic [CntW-1:0] cnt_nxt;
  } ptr_upd_t;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StExec = 5'b00010,
    StRdF  = 5'b00100,
    StRdR  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  // ring index plus offset, wrapped at Depth (offset never above Depth)
  function automatic logic [IdxW-1:0] idx_add(input logic [IdxW-1:0] base,
                                              input logic [CntW-1:0] off);
    logic [CntW:0] sum;
    sum = (CntW+1)'(base) + (CntW+1)'(off);
    if (sum >= (CntW+1)'(Depth)) begin
      sum = sum - (CntW+1)'(Depth);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

// File: src/bounded_double_ended_queue.sv
// top level: bounded double-ended queue over a ring buffer in one ram
// A bounded deque of signed 32-bit words kept in a 16-entry ring buffer ram with a head
// index and an entry count in flops. Each input transaction carries an action (insert
// front, insert rear, delete front, delete rear, no operation) and a word; each yields
// exactly one result transaction with the ok flag, the front and rear words after the
// action (all ones when empty), empty and full flags and the count. One item is handled
// at a time: after acceptance it passes the update and write, the read of the front slot,
// the read of the rear slot through the single registered ram read port, then result
// assembly, which loads the output register once that is free. The next item is accepted
// when the block is back in idle.
// The output register lets the next item be accepted while a result still waits.
// The capacity register (reset 16, its effective value saturated to the ram depth)
// is written through the config channel, which is always ready; write it only while idle.
// No clearing pass after reset: only slots inside the live window reach a result.
module bounded_double_ended_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bdeq_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bdeq_pkg::out_t             out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bdeq_pkg::CapW-1:0]  cfg_data_i
);

  bdeq_pkg::state_e state_q, state_d;

  logic [bdeq_pkg::ActW-1:0]  act_q, act_d;
  logic [bdeq_pkg::DataW-1:0] val_q, val_d;
  logic [bdeq_pkg::IdxW-1:0]  head_q, head_d;
  logic [bdeq_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [bdeq_pkg::CapW-1:0]  cap_q, cap_d;
  logic                       ok_q, ok_d;
  logic [bdeq_pkg::DataW-1:0] front_q, front_d;
  logic                       out_valid_q, out_valid_d;
  bdeq_pkg::out_t             out_data_q, out_data_d;

  logic [bdeq_pkg::CntW-1:0]  cap_eff;
  bdeq_pkg::ptr_upd_t         upd;

  logic                       in_accept;
  logic                       out_free;
  logic                       ram_we;
  logic                       ram_re;
  logic [bdeq_pkg::IdxW-1:0]  ram_raddr;
  logic [bdeq_pkg::DataW-1:0] ram_rdata;

  // capacity saturates at the ram depth
  assign cap_eff = (int'(cap_q) > bdeq_pkg::Depth) ? bdeq_pkg::CntW'(bdeq_pkg::Depth)
                                                   : bdeq_pkg::CntW'(cap_q);

  bdeq_ptr u_ptr (
    .action_i (act_q),
    .head_i   (head_q),
    .cnt_i    (cnt_q),
    .cap_i    (cap_eff),
    .upd_o    (upd)
  );

  bdeq_ram #(
    .Width (bdeq_pkg::DataW),
    .Depth (bdeq_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (upd.wr_addr),
    .wdata_i (val_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = state_q != bdeq_pkg::StIdle;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // the write happens in the update state, both reads come after it, so no
  // read ever overlaps a write of the same transaction
  assign ram_we = (state_q == bdeq_pkg::StExec) && upd.wr_en;
  assign ram_re = (state_q == bdeq_pkg::StRdF) || (state_q == bdeq_pkg::StRdR);

  always_comb begin
    if (state_q == bdeq_pkg::StRdR) begin
      // rear slot sits count-1 past the head
      ram_raddr = bdeq_pkg::idx_add(head_q, cnt_q - 1'b1);
    end else begin
      ram_raddr = head_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    val_d       = val_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    cap_d       = cap_q;
    ok_d        = ok_q;
    front_d     = front_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (cfg_valid_i && cfg_ready_o) begin
      cap_d = cfg_data_i;
    end

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      bdeq_pkg::StIdle: begin
        if (in_accept) begin
          act_d   = in_data_i.action;
          val_d   = in_data_i.value;
          state_d = bdeq_pkg::StExec;
        end
      end
      bdeq_pkg::StExec: begin
        head_d  = upd.head_nxt;
        cnt_d   = upd.cnt_nxt;
        ok_d    = upd.ok;
        state_d = bdeq_pkg::StRdF;
      end
      bdeq_pkg::StRdF: begin
        state_d = bdeq_pkg::StRdR;
      end
      bdeq_pkg::StRdR: begin
        // front word arrives now, rear read is in flight
        front_d = ram_rdata;
        state_d = bdeq_pkg::StDone;
      end
      bdeq_pkg::StDone: begin
        // ram read data holds while we wait for the output register
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_data_d.ok       = ok_q;
          out_data_d.is_empty = cnt_q == '0;
          out_data_d.is_full  = cnt_q >= cap_eff;
          out_data_d.count    = bdeq_pkg::OutCntW'(cnt_q);
          if (cnt_q == '0) begin
            out_data_d.front_value = '1;
            out_data_d.rear_value  = '1;
          end else begin
            out_data_d.front_value = front_q;
            out_data_d.rear_value  = ram_rdata;
          end
          state_d = bdeq_pkg::StIdle;
        end
      end
      default: begin
        state_d = bdeq_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdeq_pkg::StIdle;
      head_q      <= '0;
      cnt_q       <= '0;
      cap_q       <= bdeq_pkg::CapReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    val_q      <= val_d;
    ok_q       <= ok_d;
    front_q    <= front_d;
    out_data_q <= out_data_d;
  end

  // count never passes the ring size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= bdeq_pkg::Depth)
    else $error("entry count above ring depth");

  // every ram write is an insert that grows the count by one
  a_write_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("ram write without count increment");

  // pointers only move in the update state
  a_ptr_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bdeq_pkg::StExec) |=> ($stable(head_q) && $stable(cnt_q)))
    else $error("head or count moved outside update");

  // a waiting result is never overwritten by the next one
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bdeq_pkg::StDone && out_valid_q && out_stall_i)
      |=> (state_q == bdeq_pkg::StDone && out_valid_q))
    else $error("result overwritten while stalled");

endmodule

// File: src/bdeq_ram.sv
// generic single-write, single-read ram with registered read data
module bdeq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bdeq_ptr.sv
// head and count update, ok flag and write address for one operation
module bdeq_ptr (
  input  logic [bdeq_pkg::ActW-1:0] action_i,
  input  logic [bdeq_pkg::IdxW-1:0] head_i,
  input  logic [bdeq_pkg::CntW-1:0] cnt_i,
  input  logic [bdeq_pkg::CntW-1:0] cap_i,
  output bdeq_pkg::ptr_upd_t        upd_o
);

  logic has_room;
  logic has_entry;

  assign has_room  = cnt_i < cap_i;
  assign has_entry = cnt_i != '0;

  always_comb begin
    upd_o          = '0;
    upd_o.ok       = 1'b1;
    upd_o.head_nxt = head_i;
    upd_o.cnt_nxt  = cnt_i;
    upd_o.wr_addr  = head_i;
    unique case (action_i)
      bdeq_pkg::ActInsFront: begin
        if (has_room) begin
          upd_o.head_nxt = bdeq_pkg::idx_add(head_i, bdeq_pkg::CntW'(bdeq_pkg::Depth - 1));
          upd_o.wr_addr  = upd_o.head_nxt;
          upd_o.wr_en    = 1'b1;
          upd_o.cnt_nxt  = cnt_i + 1'b1;
        end else begin
          upd_o.ok = 1'b0;
        end
      end
      bdeq_pkg::ActInsRear: begin
        if (has_room) begin
          upd_o.wr_addr = bdeq_pkg::idx_add(head_i, cnt_i);
          upd_o.wr_en   = 1'b1;
          upd_o.cnt_nxt = cnt_i + 1'b1;
        end else begin
          upd_o.ok = 1'b0;
        end
      end
      bdeq_pkg::ActDelFront: begin
        if (has_entry) begin
          upd_o.head_nxt = bdeq_pkg::idx_add(head_i, bdeq_pkg::CntW'(1));
          upd_o.cnt_nxt  = cnt_i - 1'b1;
        end else begin
          upd_o.ok = 1'b0;
        end
      end
      bdeq_pkg::ActDelRear: begin
        if (has_entry) begin
          upd_o.cnt_nxt = cnt_i - 1'b1;
        end else begin
          upd_o.ok = 1'b0;
        end
      end
      default: begin
        // no operation and unused codes leave the queue alone
      end
    endcase
  end

endmodule

// File: verif/bdeq_checker.sv
// checker for the bounded double-ended queue: predicts every result and compares it
`timescale 1ns / 1ps

module bdeq_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  bdeq_pkg::in_t             in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  bdeq_pkg::out_t            out_data_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [bdeq_pkg::CapW-1:0] cfg_data_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  // shadow copy of the ring, head, entry count and capacity
  logic [bdeq_pkg::DataW-1:0]   ring [bdeq_pkg::Depth];
  logic [bdeq_pkg::IdxW-1:0]    front_idx;
  logic [bdeq_pkg::OutCntW-1:0] held;
  logic [bdeq_pkg::CapW-1:0]    capacity;

  bdeq_pkg::out_t expected_results[$];
  bdeq_pkg::out_t want;

  task automatic report_mismatch(input string what, input logic [bdeq_pkg::DataW-1:0] got,
                                 input logic [bdeq_pkg::DataW-1:0] exp_word);
    fail_count_o++;
    if (fail_count_o <= 40) begin
      $display("checker: %s mismatch, got %h wanted %h at %0t", what, got, exp_word, $time);
    end
  endtask

  // applies one operation to the shadow deque and returns the result it yields
  function automatic bdeq_pkg::out_t apply_deque_op(input bdeq_pkg::in_t op);
    logic [bdeq_pkg::CapW-1:0] limit;
    bdeq_pkg::out_t res;
    limit = (capacity > bdeq_pkg::CapW'(bdeq_pkg::Depth)) ? bdeq_pkg::CapW'(bdeq_pkg::Depth)
                                                          : capacity;
    res.ok = 1'b1;
    case (op.action)
      bdeq_pkg::ActInsFront: begin
        if (held < limit) begin
          front_idx = front_idx - 1'b1;
          ring[front_idx] = op.value;
          held = held + 1'b1;
        end else begin
          res.ok = 1'b0;
        end
      end
      bdeq_pkg::ActInsRear: begin
        if (held < limit) begin
          ring[bdeq_pkg::IdxW'(front_idx + held)] = op.value;
          held = held + 1'b1;
        end else begin
          res.ok = 1'b0;
        end
      end
      bdeq_pkg::ActDelFront: begin
        if (held != 0) begin
          front_idx = front_idx + 1'b1;
          held = held - 1'b1;
        end else begin
          res.ok = 1'b0;
        end
      end
      bdeq_pkg::ActDelRear: begin
        if (held != 0) begin
          held = held - 1'b1;
        end else begin
          res.ok = 1'b0;
        end
      end
      default: begin
        // no operation, unknown codes included
      end
    endcase
    if (held != 0) begin
      res.front_value = ring[front_idx];
      res.rear_value  = ring[bdeq_pkg::IdxW'(front_idx + held - 1'b1)];
    end else begin
      res.front_value = '1;
      res.rear_value  = '1;
    end
    res.is_empty = (held == 0);
    res.is_full  = (held >= limit);
    res.count    = held;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_idx = '0;
      held = '0;
      capacity = bdeq_pkg::CapReset;
      expected_results.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // results leave before new transactions are predicted
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data_i.front_value, '1);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.ok !== want.ok)
            report_mismatch("ok", bdeq_pkg::DataW'(out_data_i.ok),
                            bdeq_pkg::DataW'(want.ok));
          if (out_data_i.front_value !== want.front_value)
            report_mismatch("front_value", out_data_i.front_value, want.front_value);
          if (out_data_i.rear_value !== want.rear_value)
            report_mismatch("rear_value", out_data_i.rear_value, want.rear_value);
          if (out_data_i.is_empty !== want.is_empty)
            report_mismatch("is_empty", bdeq_pkg::DataW'(out_data_i.is_empty),
                            bdeq_pkg::DataW'(want.is_empty));
          if (out_data_i.is_full !== want.is_full)
            report_mismatch("is_full", bdeq_pkg::DataW'(out_data_i.is_full),
                            bdeq_pkg::DataW'(want.is_full));
          if (out_data_i.count !== want.count)
            report_mismatch("count", bdeq_pkg::DataW'(out_data_i.count),
                            bdeq_pkg::DataW'(want.count));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        capacity = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(apply_deque_op(in_data_i));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// File: verif/testbench.sv
// top of the deque testbench: clock, reset, stimulus, receiver stalls and the verdict
`timescale 1ns / 1ps

module testbench;

  // generous bound on the cycle count for the hang guard
  localparam int CycleLimit = 400000;

  typedef enum logic [1:0] {
    StallNone,
    StallCoin,
    StallEvery3,
    StallHeavy
  } stall_mode_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  bdeq_pkg::in_t             in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  bdeq_pkg::out_t            out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [bdeq_pkg::CapW-1:0] cfg_data = '0;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          stall_run = 0;
  stall_mode_e stall_mode = StallNone;

  always #1 clk_i = ~clk_i;

  bounded_double_ended_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // watches all three channels, predicts each result and compares
  bdeq_checker deque_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // hang guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // receiver back-pressure: a random mode held for a random stretch
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_run  <= $urandom_range(16, 160);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      StallNone:   out_stall <= 1'b0;
      StallCoin:   out_stall <= $urandom_range(0, 1);
      StallEvery3: out_stall <= ((stall_run % 3) == 0);
      default:     out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // one input transaction: valid rises (or stays high), then wait for acceptance
  task automatic send_op(input logic [bdeq_pkg::ActW-1:0] action,
                         input logic [bdeq_pkg::DataW-1:0] word);
    bdeq_pkg::in_t op;
    op.action = action;
    op.value  = word;
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // sender goes quiet until every predicted result has been taken
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // capacity write, only ever issued with the block idle
  task automatic write_capacity(input logic [bdeq_pkg::CapW-1:0] cap);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // random traffic at one capacity; insert_pct steers the fill level
  task automatic run_phase(input logic [bdeq_pkg::CapW-1:0] cap, input int insert_pct,
                           input int n_ops, input bit bursty);
    int burst_left;
    int gap;
    int roll;
    logic [bdeq_pkg::ActW-1:0]  act;
    logic [bdeq_pkg::DataW-1:0] word;
    write_capacity(cap);
    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < n_ops; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        // no operation or one of the unknown codes above it
        act = bdeq_pkg::ActNop | bdeq_pkg::ActW'($urandom_range(0, 3));
      end else if (roll < 5 + insert_pct * 95 / 100) begin
        act = $urandom_range(0, 1) ? bdeq_pkg::ActInsRear : bdeq_pkg::ActInsFront;
      end else begin
        act = $urandom_range(0, 1) ? bdeq_pkg::ActDelRear : bdeq_pkg::ActDelFront;
      end
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       word = 32'h8000_0000;
          1:       word = 32'h7fff_ffff;
          2:       word = '1;
          default: word = '0;
        endcase
      end else begin
        word = $urandom;
      end
      send_op(act, word);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = bursty ? $urandom_range(1, 8) : 0;
        if ($urandom_range(0, 49) == 0) begin
          // occasional full drain in the middle of traffic
          wait_for_results();
        end else if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset capacity: deletes on empty, extreme words at both ends, every action code
    send_op(bdeq_pkg::ActDelFront, $urandom);
    send_op(bdeq_pkg::ActDelRear, $urandom);
    send_op(bdeq_pkg::ActInsFront, 32'h8000_0000);
    send_op(bdeq_pkg::ActInsRear, 32'h7fff_ffff);
    send_op(bdeq_pkg::ActInsFront, '1);
    send_op(bdeq_pkg::ActInsRear, '0);
    send_op(bdeq_pkg::ActNop, $urandom);
    for (int k = 1; k < 4; k++) send_op(bdeq_pkg::ActNop | bdeq_pkg::ActW'(k), $urandom);
    send_op(bdeq_pkg::ActDelFront, $urandom);
    send_op(bdeq_pkg::ActDelRear, $urandom);
    send_op(bdeq_pkg::ActDelFront, $urandom);
    send_op(bdeq_pkg::ActDelRear, $urandom);
    send_op(bdeq_pkg::ActDelRear, $urandom);

    // zero capacity: reads empty and full, nothing fits
    write_capacity('0);
    send_op(bdeq_pkg::ActInsFront, $urandom);
    send_op(bdeq_pkg::ActInsRear, $urandom);
    send_op(bdeq_pkg::ActDelFront, $urandom);

    // capacity of one: second insert fails
    write_capacity(bdeq_pkg::CapW'(1));
    send_op(bdeq_pkg::ActInsRear, 32'h5555_5555);
    send_op(bdeq_pkg::ActInsFront, 32'haaaa_aaaa);
    send_op(bdeq_pkg::ActDelRear, $urandom);
    send_op(bdeq_pkg::ActInsFront, 32'h1234_5678);
    send_op(bdeq_pkg::ActDelFront, $urandom);

    // random part: saturating capacity first and fill-heavy, so that the
    // following write lowers the capacity below the entry count
    run_phase('1, 80, 100, 1'b1);
    run_phase(bdeq_pkg::CapW'(4), 30, 100, 1'b0);
    run_phase(bdeq_pkg::CapReset, 60, 100, 1'b1);
    run_phase(bdeq_pkg::CapW'(8), 50, 100, 1'b0);
    run_phase('0, 50, 100, 1'b1);
    run_phase(bdeq_pkg::CapW'(1), 50, 100, 1'b1);
    run_phase(bdeq_pkg::CapW'(17), 70, 100, 1'b0);
    run_phase(bdeq_pkg::CapW'(5), 40, 100, 1'b1);
    run_phase(bdeq_pkg::CapW'(2), 50, 100, 1'b0);
    run_phase(bdeq_pkg::CapReset, 50, 100, 1'b1);

    // let any stray result show up before the verdict
    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: bounded_double_ended_queue.f
src/bdeq_pkg.sv
src/bdeq_ram.sv
src/bdeq_ptr.sv
src/bounded_double_ended_queue.sv
verif/bdeq_checker.sv
verif/testbench.sv
